[src/lbp_pkg.sv]
`timescale 1ns / 1ps

package lbp_pkg;

  // Stream geometry
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned PEND_BITS    = 7;
  localparam int unsigned POS_OUT_BITS = 32;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned COUNT_BITS   = 6;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Error codes
  localparam logic ERR_NONE    = 1'b0;
  localparam logic ERR_REFUSED = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } lbp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic final_step;
  } lbp_sts_t;

endpackage

[src/lbp_in_if.sv]
`timescale 1ns / 1ps

interface lbp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] field_value;
  logic [5:0]  field_width;

  modport source (output valid, output mode, output field_value, output field_width,
                  input ready);
  modport sink (input valid, input mode, input field_value, input field_width,
                output ready);
endinterface

[src/lbp_out_if.sv]
`timescale 1ns / 1ps

interface lbp_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        last;
  logic [31:0] bit_position;
  logic        error;

  modport source (output valid, output byte_valid, output out_byte, output last,
                  output bit_position, output error, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input last,
                input bit_position, input error, output ready);
endinterface

[src/lbp_ctrl.sv]
`timescale 1ns / 1ps

module lbp_ctrl
  import lbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lbp_sts_t sts,
  output lbp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } lbp_state_t;

  lbp_state_t state;
  lbp_state_t state_next;

  // Take a new transaction only between items
  assign in_ready = (state == S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.step = (state == S_EMIT) && sts.slot_free;

  // Advance through the emit phase one result at a time
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free && sts.final_step) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/lbp_dpath.sv]
`timescale 1ns / 1ps

module lbp_dpath
  import lbp_pkg::*;
#(
  parameter int unsigned POSITION_BITS  = 32,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lbp_cmd_t                cmd,
  output lbp_sts_t                sts,
  input  logic                    mode,
  input  logic [VALUE_BITS-1:0]   field_value,
  input  logic [COUNT_BITS-1:0]   field_width,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    byte_valid,
  output logic [BYTE_BITS-1:0]    out_byte,
  output logic                    last,
  output logic [POS_OUT_BITS-1:0] bit_position,
  output logic                    error
);

  localparam int unsigned ACC_W  = MAX_FIELD_BITS + PEND_BITS;
  localparam int unsigned BITS_W = $clog2(ACC_W + 1);
  localparam int unsigned PC_W   = $clog2(PEND_BITS + 1);

  // Architectural state
  logic [PEND_BITS-1:0]     pend_bits;
  logic [PC_W-1:0]          pend_cnt;
  logic [POSITION_BITS-1:0] pos;

  // Working registers for the item in flight
  logic [ACC_W-1:0]  acc;
  logic [BITS_W-1:0] bits;
  logic              err_code;

  // Load-side logic
  logic [MAX_FIELD_BITS-1:0] fmask;
  logic [MAX_FIELD_BITS-1:0] masked;
  logic [POSITION_BITS:0]    pos_sum;
  logic                      too_wide;
  logic                      refused;
  logic [ACC_W-1:0]          acc_load;
  logic [BITS_W-1:0]         bits_load;

  // Step-side logic
  logic              has_byte;
  logic              final_step;
  logic [ACC_W-1:0]  acc_next;
  logic [BITS_W-1:0] bits_next;

  // Mask the field and check it against the width limit and the position range
  always_comb begin
    fmask    = ~({MAX_FIELD_BITS{1'b1}} << field_width);
    masked   = field_value[MAX_FIELD_BITS-1:0] & fmask;
    pos_sum  = {1'b0, pos} + (POSITION_BITS + 1)'(field_width);
    too_wide = field_width > COUNT_BITS'(MAX_FIELD_BITS);
    refused  = (mode == MODE_WRITE) && (too_wide || pos_sum[POSITION_BITS]);
    if (mode == MODE_FLUSH) begin
      acc_load  = ACC_W'(pend_bits);
      bits_load = (pend_cnt != '0) ? BITS_W'(BYTE_BITS) : '0;
    end else if (refused) begin
      acc_load  = ACC_W'(pend_bits);
      bits_load = BITS_W'(pend_cnt);
    end else begin
      acc_load  = ACC_W'(pend_bits) | (ACC_W'(masked) << pend_cnt);
      bits_load = BITS_W'(pend_cnt) + BITS_W'(field_width);
    end
  end

  // Drop one byte from the accumulator for each result that carries one
  always_comb begin
    has_byte   = bits >= BITS_W'(BYTE_BITS);
    final_step = {1'b0, bits} < (BITS_W + 1)'(2 * BYTE_BITS);
    acc_next   = has_byte ? (acc >> BYTE_BITS) : acc;
    bits_next  = has_byte ? (bits - BITS_W'(BYTE_BITS)) : bits;
  end

  assign sts.slot_free  = !out_valid || out_ready;
  assign sts.final_step = final_step;

  // Hold the item in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc      <= acc_load;
      bits     <= bits_load;
      err_code <= refused ? ERR_REFUSED : ERR_NONE;
    end else if (cmd.step) begin
      acc  <= acc_next;
      bits <= bits_next;
    end
  end

  // Update position on accept, leftover bits at the end of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
      pos       <= '0;
    end else begin
      if (cmd.load && (mode == MODE_WRITE) && !refused) begin
        pos <= pos_sum[POSITION_BITS-1:0];
      end
      if (cmd.step && final_step) begin
        pend_bits <= acc_next[PEND_BITS-1:0];
        pend_cnt  <= bits_next[PC_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      byte_valid   <= has_byte;
      out_byte     <= has_byte ? acc[BYTE_BITS-1:0] : '0;
      last         <= final_step;
      bit_position <= POS_OUT_BITS'(pos);
      error        <= err_code;
    end
  end

endmodule

[src/lsb_first_bit_packer_core.sv]
`timescale 1ns / 1ps
// LSB-first bit packer: each write transaction appends the low field_width bits of
// field_value (0 to MAX_FIELD_BITS) to the stream and emits every completed byte,
// earliest bit at bit zero; a flush emits leftover bits, if any, zero-padded as
// one byte. Every result carries the running bit count; a write that would
// overflow the POSITION_BITS counter or exceed MAX_FIELD_BITS is refused with
// error set and no state change. An item is accepted and then emitted one result
// per step (1 to 4 results); the limit is the emit loop, which moves one byte per
// cycle into a single output register whenever that register is free. The input
// is not taken while an item is being emitted; a finished result may still wait
// in the output register when the next transaction is accepted.

module lsb_first_bit_packer_core
  import lbp_pkg::*;
#(
  parameter int unsigned POSITION_BITS  = 32,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  lbp_in_if.sink    in_ch,
  lbp_out_if.source out_ch
);

  lbp_cmd_t cmd;
  lbp_sts_t sts;

  lbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbp_dpath #(
    .POSITION_BITS  (POSITION_BITS),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (in_ch.mode),
    .field_value  (in_ch.field_value),
    .field_width  (in_ch.field_width),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .byte_valid   (out_ch.byte_valid),
    .out_byte     (out_ch.out_byte),
    .last         (out_ch.last),
    .bit_position (out_ch.bit_position),
    .error        (out_ch.error)
  );

endmodule

[src/lbp_checker.sv]
`timescale 1ns / 1ps

module lbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        byte_valid,
  input logic [7:0]  out_byte,
  input logic        last,
  input logic        error
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  // A result without a byte always closes its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("byteless result not marked last");

  // A refused write carries no byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !byte_valid && last)
    else $error("error result carries a byte");

  // Drop ready after a transaction until its results are issued
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

endmodule

bind lsb_first_bit_packer_core lbp_checker u_lbp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .byte_valid (out_ch.byte_valid),
  .out_byte   (out_ch.out_byte),
  .last       (out_ch.last),
  .error      (out_ch.error)
);

[tb/tb_lsb_first_bit_packer_core.sv]
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_core;
  import lbp_pkg::*;

  // Default counter width; only oversize fields can be refused in a run this short
  localparam int unsigned POS_BITS     = 32;
  localparam int unsigned MAX_FIELD    = 32;
  localparam bit [63:0]   POS_TOP      = (64'd2 << (POS_BITS - 1)) - 64'd1;
  localparam int          RANDOM_ITEMS = 370;
  localparam int          DIR_ROWS     = 21;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          TAIL_CYCLES  = 10;

  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic [5:0]  width;
  } pk_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] bit_position;
    logic        err;
  } pk_result_t;

  typedef struct packed {
    pk_item_t   item;
    logic       typed;
    pk_result_t want;
  } dir_row_t;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic sink_ready  = 1'b0;
  logic sink_steady = 1'b0;
  int   sink_hold   = 0;
  bit   src_steady  = 1'b0;

  lbp_in_if  in_ch ();
  lbp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  lsb_first_bit_packer_core #(
    .POSITION_BITS (POS_BITS),
    .MAX_FIELD_BITS(MAX_FIELD)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Packer state as the testbench sees it
  bit [6:0]   pend_bits;
  bit [2:0]   pend_cnt;
  bit [63:0]  bit_pos;
  pk_result_t step_res [4];
  int         step_n;

  pk_result_t stream_results [$];
  dir_row_t   dir_rows [DIR_ROWS];
  int         accepted_items = 0;
  int         mismatch_count = 0;
  int         idle_cycles    = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void emit(logic bv, logic [7:0] b, logic lst, logic e);
    step_res[step_n] = '{bv, b, lst, bit_pos[31:0], e};
    step_n++;
  endfunction

  // Work out the results of one item and advance the packer state
  function automatic void pack_field(pk_item_t it);
    bit [63:0] acc;
    bit [6:0]  nbits;
    step_n = 0;
    if (it.mode == MODE_FLUSH) begin
      if (pend_cnt == 0) begin
        emit(1'b0, 8'h00, 1'b1, ERR_NONE);
      end else begin
        emit(1'b1, {1'b0, pend_bits}, 1'b1, ERR_NONE);
        pend_bits = '0;
        pend_cnt  = '0;
      end
      return;
    end
    // Refuse oversize fields and writes past the counter top
    if (it.width > MAX_FIELD || bit_pos > POS_TOP - 64'(it.width)) begin
      emit(1'b0, 8'h00, 1'b1, ERR_REFUSED);
      return;
    end
    acc = {32'd0, it.value};
    if (it.width < 32) acc &= (64'd1 << it.width) - 64'd1;
    acc     = {57'd0, pend_bits} | (acc << pend_cnt);
    nbits   = 7'(pend_cnt) + 7'(it.width);
    bit_pos = (bit_pos + 64'(it.width)) & POS_TOP;
    // Emit every complete low byte
    while (nbits >= 7'd8) begin
      emit(1'b1, acc[7:0], 1'b0, ERR_NONE);
      acc >>= 8;
      nbits -= 7'd8;
    end
    pend_bits = acc[6:0];
    pend_cnt  = nbits[2:0];
    if (step_n == 0) emit(1'b0, 8'h00, 1'b1, ERR_NONE);
    else step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic dir_row_t typed_row(logic m, logic [31:0] v, logic [5:0] w, logic bv,
                                         logic [7:0] b, logic [31:0] pos, logic e);
    return '{'{m, v, w}, 1'b1, '{bv, b, 1'b1, pos, e}};
  endfunction

  function automatic dir_row_t pred_row(logic m, logic [31:0] v, logic [5:0] w);
    return '{'{m, v, w}, 1'b0, '0};
  endfunction

  // Check result transactions, then predict input transactions
  always @(posedge clk) begin
    pk_result_t want;
    if (rst) begin
      pend_bits = '0;
      pend_cnt  = '0;
      bit_pos   = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (stream_results.size() == 0) begin
          $error("result with no expectation waiting: out_byte 0x%0h", out_ch.out_byte);
          mismatch_count++;
        end else begin
          want = stream_results.pop_front();
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_ch.byte_valid));
          check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
          check_field("last", 32'(want.last), 32'(out_ch.last));
          check_field("bit_position", want.bit_position, out_ch.bit_position);
          check_field("error", 32'(want.err), 32'(out_ch.error));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pack_field(pk_item_t'({in_ch.mode, in_ch.field_value, in_ch.field_width}));
        if (accepted_items < DIR_ROWS && dir_rows[accepted_items].typed) begin
          stream_results.push_back(dir_rows[accepted_items].want);
        end else begin
          for (int k = 0; k < step_n; k++) stream_results.push_back(step_res[k]);
        end
        accepted_items++;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      sink_ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      sink_hold  <= pick_gap();
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lsb_first_bit_packer_core: mismatch");
      $finish;
    end
  end

  // Hold one item on the input until it is taken
  task automatic send_item(pk_item_t it);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.field_value <= it.value;
    in_ch.field_width <= it.width;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (stream_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    pk_item_t it;
    int       kind;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_WRITE;
    in_ch.field_value = '0;
    in_ch.field_width = '0;

    // Extremes, refusals, flushes and exact byte boundaries
    dir_rows[0]  = typed_row(MODE_FLUSH, 32'h0, 6'd0, 1'b0, 8'h00, 32'd0, ERR_NONE);
    dir_rows[1]  = typed_row(MODE_WRITE, 32'hffff_ffff, 6'd0, 1'b0, 8'h00, 32'd0, ERR_NONE);
    dir_rows[2]  = typed_row(MODE_WRITE, 32'h1234_5678, 6'd33, 1'b0, 8'h00, 32'd0, ERR_REFUSED);
    dir_rows[3]  = typed_row(MODE_WRITE, 32'hffff_ffff, 6'd63, 1'b0, 8'h00, 32'd0, ERR_REFUSED);
    dir_rows[4]  = pred_row(MODE_WRITE, 32'hffff_ffff, 6'd32);
    dir_rows[5]  = typed_row(MODE_WRITE, 32'hffff_ffff, 6'd1, 1'b0, 8'h00, 32'd33, ERR_NONE);
    dir_rows[6]  = typed_row(MODE_FLUSH, 32'hffff_ffff, 6'd63, 1'b1, 8'h01, 32'd33, ERR_NONE);
    dir_rows[7]  = typed_row(MODE_FLUSH, 32'h0, 6'd0, 1'b0, 8'h00, 32'd33, ERR_NONE);
    dir_rows[8]  = typed_row(MODE_WRITE, 32'h0000_007f, 6'd7, 1'b0, 8'h00, 32'd40, ERR_NONE);
    dir_rows[9]  = pred_row(MODE_WRITE, 32'ha5a5_a5a5, 6'd32);
    dir_rows[10] = pred_row(MODE_WRITE, 32'h0, 6'd32);
    dir_rows[11] = pred_row(MODE_WRITE, 32'hffff_ff00, 6'd8);
    dir_rows[12] = pred_row(MODE_WRITE, 32'h0000_001f, 6'd5);
    dir_rows[13] = pred_row(MODE_WRITE, 32'h0, 6'd3);
    dir_rows[14] = pred_row(MODE_WRITE, 32'h8000_0001, 6'd32);
    dir_rows[15] = pred_row(MODE_FLUSH, 32'h0, 6'd0);
    dir_rows[16] = pred_row(MODE_WRITE, 32'hffff_ffff, 6'd31);
    dir_rows[17] = pred_row(MODE_WRITE, 32'h0, 6'd1);
    dir_rows[18] = pred_row(MODE_WRITE, 32'h0000_ffff, 6'd16);
    dir_rows[19] = typed_row(MODE_WRITE, 32'h0, 6'd33, 1'b0, 8'h00, 32'd200, ERR_REFUSED);
    dir_rows[20] = pred_row(MODE_FLUSH, 32'h5555_aaaa, 6'd42);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) send_item(dir_rows[r].item);

    // Random items, with bursts that have no idling on either side
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady <= ($urandom_range(0, 3) == 0);
      end
      kind     = $urandom_range(0, 99);
      it.value = $urandom;
      if ($urandom_range(0, 7) == 0) it.value = $urandom_range(0, 1) ? '1 : '0;
      it.mode = MODE_WRITE;
      if (kind < 18) begin
        it.mode  = MODE_FLUSH;
        it.width = 6'($urandom_range(0, 63));
      end else if (kind < 24) begin
        it.width = 6'($urandom_range(33, 63));
      end else if (kind < 34) begin
        it.width = $urandom_range(0, 1) ? 6'd32 : 6'd0;
      end else begin
        it.width = 6'($urandom_range(1, 31));
      end
      send_item(it);
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    // Finish with a short run of extremes under random stalls
    src_steady  = 1'b0;
    sink_steady <= 1'b0;
    send_item('{MODE_WRITE, 32'hffff_ffff, 6'd1});
    send_item('{MODE_WRITE, 32'hffff_ffff, 6'd0});
    send_item('{MODE_WRITE, $urandom, 6'd32});
    send_item('{MODE_FLUSH, $urandom, 6'd0});
    send_item('{MODE_WRITE, $urandom, 6'd63});
    in_ch.valid <= 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && stream_results.size() == 0) begin
      $display("lsb_first_bit_packer_core: match");
    end else begin
      $display("lsb_first_bit_packer_core: mismatch");
    end
    $finish;
  end

endmodule

[lsb_first_bit_packer_core.f]
src/lbp_pkg.sv
src/lbp_in_if.sv
src/lbp_out_if.sv
src/lbp_ctrl.sv
src/lbp_dpath.sv
src/lsb_first_bit_packer_core.sv
src/lbp_checker.sv
tb/tb_lsb_first_bit_packer_core.sv
